@@ src/tssc_pkg.sv @@
`default_nettype none
package tssc_pkg;

    localparam int TableBitsDefault = 12;
    localparam int MaxScoreDefault  = 64;

    // Result action codes.
    localparam logic [2:0] ACT_REFINE_DEEP  = 3'd0;
    localparam logic [2:0] ACT_REFINE_NEW   = 3'd1;
    localparam logic [2:0] ACT_PROMOTE      = 3'd2;
    localparam logic [2:0] ACT_REPLACE_DEEP = 3'd3;
    localparam logic [2:0] ACT_REPLACE_NEW  = 3'd4;
    localparam logic [2:0] ACT_CLEARED      = 3'd5;

    // Request codes.
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Register index of the search date.
    localparam logic REG_SEARCH_DATE = 1'b0;

    // One slot of a bucket: key pair plus info word.
    typedef struct packed {
        logic [63:0]       player;
        logic [63:0]       opponent;
        logic [7:0]        depth;
        logic [7:0]        date;
        logic signed [7:0] lower;
        logic signed [7:0] upper;
        logic signed [7:0] move;
    } slot_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic capture;   // latch the input item and issue the bucket read
        logic compute;   // evaluate and write back the bucket
        logic clr_write; // write zero at the clear address
        logic clr_start; // reset the clear address
        logic clr_step;  // advance the clear address
        logic load_out;  // load the result register
        logic is_clear;  // result is the clear result
    } ctl_cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic clr_last;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ src/two_slot_search_cache_update.sv @@
// Channel  | Handshake                 | Payload
// input    | in_valid / in_stall       | req_type, pos_hash, discs, depth, window, score, move
// output   | out_valid / out_stall     | action, stored_lower/upper/move/date
// config   | APB psel/penable/pwrite   | search_date at address 0
//
// A store reads the bucket when accepted, then evaluates and writes it back once
// the result register has room. A clear resets the clear address when accepted, then
// zeroes one bucket a cycle through the memory write port, waiting at the last one for room.
// After reset the same sweep runs over every bucket before the first transfer.
// The next item is accepted while a result waits; a stalled result holds the next one.
`default_nettype none
module two_slot_search_cache_update #(
    parameter int TABLE_BITS      = tssc_pkg::TableBitsDefault,
    parameter int MAX_SCORE_VALUE = tssc_pkg::MaxScoreDefault
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [1:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire logic [63:0]       pos_hash,
    input  wire logic [63:0]       player_discs,
    input  wire logic [63:0]       opponent_discs,
    input  wire logic [7:0]        search_depth,
    input  wire logic signed [7:0] window_low,
    input  wire logic signed [7:0] window_high,
    input  wire logic signed [7:0] result_score,
    input  wire logic signed [7:0] best_move,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             action,
    output logic signed [7:0]      stored_lower,
    output logic signed [7:0]      stored_upper,
    output logic signed [7:0]      stored_move,
    output logic [7:0]             stored_date
);
    import tssc_pkg::*;

    logic [7:0] search_date_reg;
    ctl_cmd_t   cmd;
    dp_stat_t   stat;
    logic       reg_hit;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_hit = (paddr == 2'(4 * REG_SEARCH_DATE));
    assign prdata  = reg_hit ? {24'd0, search_date_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            search_date_reg <= '0;
        else if (psel && penable && pwrite && reg_hit)
            search_date_reg <= pwdata[7:0];
    end

    tssc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    tssc_datapath #(
        .TABLE_BITS      (TABLE_BITS),
        .MAX_SCORE_VALUE (MAX_SCORE_VALUE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .search_date    (search_date_reg),
        .pos_hash       (pos_hash),
        .player_discs   (player_discs),
        .opponent_discs (opponent_discs),
        .search_depth   (search_depth),
        .window_low     (window_low),
        .window_high    (window_high),
        .result_score   (result_score),
        .best_move      (best_move),
        .action         (action),
        .stored_lower   (stored_lower),
        .stored_upper   (stored_upper),
        .stored_move    (stored_move),
        .stored_date    (stored_date)
    );

    // A loaded result never lands on one still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.load_out)
        else $error("result overwritten while stalled");

    // Evaluation and clear write never coincide.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.compute && cmd.clr_write))
        else $error("compute during clear sweep");

    // A capture is followed by evaluation, not by another capture.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.capture)
        else $error("back to back capture");

endmodule
`default_nettype wire

@@ src/tssc_datapath.sv @@
`default_nettype none
module tssc_datapath #(
    parameter int TABLE_BITS      = tssc_pkg::TableBitsDefault,
    parameter int MAX_SCORE_VALUE = tssc_pkg::MaxScoreDefault
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tssc_pkg::ctl_cmd_t        cmd,
    output tssc_pkg::dp_stat_t             stat,
    input  wire logic [7:0]                search_date,
    input  wire logic [63:0]               pos_hash,
    input  wire logic [63:0]               player_discs,
    input  wire logic [63:0]               opponent_discs,
    input  wire logic [7:0]                search_depth,
    input  wire logic signed [7:0]         window_low,
    input  wire logic signed [7:0]         window_high,
    input  wire logic signed [7:0]         result_score,
    input  wire logic signed [7:0]         best_move,
    output logic [2:0]                     action,
    output logic signed [7:0]              stored_lower,
    output logic signed [7:0]              stored_upper,
    output logic signed [7:0]              stored_move,
    output logic [7:0]                     stored_date
);
    import tssc_pkg::*;

    localparam int Depth = 1 << TABLE_BITS;
    localparam logic signed [8:0] MaxPos = 9'(MAX_SCORE_VALUE);
    localparam logic signed [8:0] MaxNeg = -9'(MAX_SCORE_VALUE);
    localparam logic [TABLE_BITS-1:0] LastAddr = TABLE_BITS'(Depth - 1);

    // Bucket memories, one per slot.
    slot_t deep_mem [Depth];
    slot_t new_mem  [Depth];
    slot_t deep_rd_reg, new_rd_reg;

    // Captured item.
    logic [TABLE_BITS-1:0] idx_reg;
    logic [63:0]           p_reg, o_reg;
    logic [7:0]            depth_reg;
    logic signed [7:0]     a_reg, b_reg, sc_reg, mv_reg;
    logic [TABLE_BITS-1:0] clr_addr_reg, clr_addr_next;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg   <= pos_hash[32 +: TABLE_BITS];
            p_reg     <= player_discs;
            o_reg     <= opponent_discs;
            depth_reg <= search_depth;
            a_reg     <= window_low;
            b_reg     <= window_high;
            sc_reg    <= result_score;
            mv_reg    <= best_move;
            deep_rd_reg <= deep_mem[pos_hash[32 +: TABLE_BITS]];
            new_rd_reg  <= new_mem[pos_hash[32 +: TABLE_BITS]];
        end
    end

    // Clear address counter.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clr_start)
            clr_addr_next = '0;
        else if (cmd.clr_step)
            clr_addr_next = clr_addr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else
            clr_addr_reg <= clr_addr_next;
    end

    assign stat.clr_last = (clr_addr_reg == LastAddr);

    function automatic logic signed [7:0] sat(input logic signed [7:0] v);
        logic signed [8:0] x;
        x = 9'(v);
        if (x > MaxPos) x = MaxPos;
        if (x < MaxNeg) x = MaxNeg;
        return x[7:0];
    endfunction

    function automatic logic [7:0] inc_sat(input logic [7:0] d);
        return (d == 8'hFF) ? d : d + 8'd1;
    endfunction

    // Update evaluation.
    logic              hi_a, lo_b, exact, is_deep, is_new, deq;
    logic [7:0]        base, date;
    logic signed [7:0] sat_sc, fl, fu;
    slot_t             rsrc, ref_s, fresh_s, w, dwr, nwr;
    logic              we_d, we_n, equal;
    logic [2:0]        act;

    always_comb
    begin
        hi_a   = sc_reg > a_reg;
        lo_b   = sc_reg < b_reg;
        exact  = hi_a && lo_b;
        base   = search_date;
        date   = exact ? inc_sat(base) : base;
        sat_sc = sat(sc_reg);
        fl = hi_a ? sat_sc : MaxNeg[7:0];
        fu = lo_b ? sat_sc : MaxPos[7:0];
        is_deep = (p_reg == deep_rd_reg.player) && (o_reg == deep_rd_reg.opponent);
        is_new  = (p_reg == new_rd_reg.player) && (o_reg == new_rd_reg.opponent);
        deq = is_deep && (depth_reg == deep_rd_reg.depth);

        // Refine the matching slot.
        rsrc  = deq ? deep_rd_reg : new_rd_reg;
        ref_s = rsrc;
        if (lo_b && sc_reg < rsrc.upper) ref_s.upper = sat_sc;
        if (hi_a)
        begin
            ref_s.move = mv_reg;
            if (sc_reg > rsrc.lower) ref_s.lower = sat_sc;
        end
        equal = 1'b0;
        if (ref_s.lower > ref_s.upper)
        begin
            ref_s.lower = fl;
            ref_s.upper = fu;
            ref_s.move  = mv_reg;
        end
        else if (ref_s.lower == ref_s.upper)
            equal = 1'b1;
        ref_s.player   = p_reg;
        ref_s.opponent = o_reg;
        ref_s.depth    = depth_reg;

        fresh_s = '{player: p_reg, opponent: o_reg, depth: depth_reg, date: date,
                    lower: fl, upper: fu, move: mv_reg};

        dwr  = deep_rd_reg;
        nwr  = new_rd_reg;
        we_d = 1'b0;
        we_n = 1'b0;
        w    = fresh_s;
        if (deq)
        begin
            w = ref_s;
            w.date = (equal && !exact) ? inc_sat(base) : date;
            dwr = w; we_d = 1'b1;
            act = ACT_REFINE_DEEP;
        end
        else if (is_new && depth_reg == new_rd_reg.depth)
        begin
            w = ref_s;
            w.date = date;
            if (date > deep_rd_reg.date ||
                (date == deep_rd_reg.date && depth_reg > deep_rd_reg.depth))
            begin
                nwr = deep_rd_reg; we_n = 1'b1;
                dwr = w; we_d = 1'b1;
                act = ACT_PROMOTE;
            end
            else
            begin
                nwr = w; we_n = 1'b1;
                act = ACT_REFINE_NEW;
            end
        end
        else if (is_deep || deep_rd_reg.date < date ||
                 (deep_rd_reg.date == date && deep_rd_reg.depth < depth_reg))
        begin
            if (!is_deep && (is_new || new_rd_reg.date < deep_rd_reg.date ||
                (new_rd_reg.date == deep_rd_reg.date &&
                 new_rd_reg.depth <= deep_rd_reg.depth)))
            begin
                nwr = deep_rd_reg; we_n = 1'b1;
            end
            dwr = fresh_s; we_d = 1'b1;
            act = ACT_REPLACE_DEEP;
        end
        else
        begin
            nwr = fresh_s; we_n = 1'b1;
            act = ACT_REPLACE_NEW;
        end
    end

    // Memory writes: update write-back or clear sweep.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_write)
        begin
            deep_mem[clr_addr_reg] <= '0;
            new_mem[clr_addr_reg]  <= '0;
        end
        else if (cmd.compute)
        begin
            if (we_d) deep_mem[idx_reg] <= dwr;
            if (we_n) new_mem[idx_reg]  <= nwr;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.is_clear)
            begin
                action       <= ACT_CLEARED;
                stored_lower <= '0;
                stored_upper <= '0;
                stored_move  <= '0;
                stored_date  <= '0;
            end
            else
            begin
                action       <= act;
                stored_lower <= w.lower;
                stored_upper <= w.upper;
                stored_move  <= w.move;
                stored_date  <= w.date;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/tssc_ctrl.sv @@
`default_nettype none
module tssc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                req_type,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tssc_pkg::ctl_cmd_t       cmd,
    input  wire tssc_pkg::dp_stat_t  stat
);
    import tssc_pkg::*;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       take, room;

    // The result register frees up when it is empty or being taken.
    assign room      = !out_valid_reg || !out_stall;
    assign in_stall  = !(state_reg == ST_IDLE);
    assign take      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_write = 1'b1;
                cmd.clr_step  = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    if (req_type == REQ_CLEAR)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (room)
                begin
                    cmd.compute  = 1'b1;
                    cmd.load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                cmd.clr_step  = 1'b1;
                if (stat.clr_last && room)
                begin
                    cmd.load_out = 1'b1;
                    cmd.is_clear = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.clr_last)
                begin
                    cmd.clr_step = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ bench/two_slot_search_cache_update_tb.sv @@
`default_nettype none
module two_slot_search_cache_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tssc_pkg::*;

    localparam int TBITS = 12;
    localparam int NBUCKETS = 1 << TBITS;
    localparam int MAXS = 64;
    localparam int IDLE_LIMIT = 30000;

    // One update or clear request as it crosses the input channel.
    typedef struct {
        logic        req;
        logic [63:0] hash;
        logic [63:0] pkey;
        logic [63:0] okey;
        logic [7:0]  depth;
        logic [7:0]  wlo;
        logic [7:0]  whi;
        logic [7:0]  score;
        logic [7:0]  move;
    } update_t;

    // One result as it crosses the output channel.
    typedef struct {
        logic [2:0] act;
        logic [7:0] lo;
        logic [7:0] up;
        logic [7:0] mv;
        logic [7:0] dt;
    } outcome_t;

    // One slot of a bucket, with bounds kept as plain integers.
    typedef struct {
        logic [63:0] pkey;
        logic [63:0] okey;
        int          depth;
        int          date;
        int          lower;
        int          upper;
        int          move;
    } slot_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = REQ_STORE;
    logic [63:0] pos_hash = '0;
    logic [63:0] player_discs = '0;
    logic [63:0] opponent_discs = '0;
    logic [7:0] search_depth = '0;
    logic signed [7:0] window_low = '0;
    logic signed [7:0] window_high = '0;
    logic signed [7:0] result_score = '0;
    logic signed [7:0] best_move = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] action;
    logic signed [7:0] stored_lower;
    logic signed [7:0] stored_upper;
    logic signed [7:0] stored_move;
    logic [7:0] stored_date;

    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    logic [63:0] key_pool_p [8];
    logic [63:0] key_pool_o [8];

    always #4 clk = ~clk;

    two_slot_search_cache_update dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pos_hash(pos_hash),
        .player_discs(player_discs), .opponent_discs(opponent_discs),
        .search_depth(search_depth), .window_low(window_low),
        .window_high(window_high), .result_score(result_score),
        .best_move(best_move),
        .out_valid(out_valid), .out_stall(out_stall),
        .action(action), .stored_lower(stored_lower), .stored_upper(stored_upper),
        .stored_move(stored_move), .stored_date(stored_date)
    );

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Cache model plus the queue of results still owed by the block.
    class cache_scoreboard;
        slot_rec_t deep_slot [NBUCKETS];
        slot_rec_t new_slot [NBUCKETS];
        int date_reg;
        outcome_t owed [$];

        function void wipe();
            slot_rec_t z;
            z = '{pkey: '0, okey: '0, depth: 0, date: 0, lower: 0, upper: 0, move: 0};
            for (int i = 0; i < NBUCKETS; i++)
            begin
                deep_slot[i] = z;
                new_slot[i] = z;
            end
        endfunction

        function new();
            date_reg = 0;
            wipe();
        endfunction

        function int clamp(input int v);
            if (v > MAXS) return MAXS;
            if (v < -MAXS) return -MAXS;
            return v;
        endfunction

        function int bump(input int d);
            return (d < 255) ? d + 1 : 255;
        endfunction

        function slot_rec_t tighten(input slot_rec_t v, input int a, input int b,
                                    input int sc, input int mv, output bit equal);
            if (sc < b && sc < v.upper) v.upper = clamp(sc);
            if (sc > a)
            begin
                v.move = mv;
                if (sc > v.lower) v.lower = clamp(sc);
            end
            equal = 1'b0;
            if (v.lower > v.upper)
            begin
                v.lower = (sc > a) ? clamp(sc) : -MAXS;
                v.upper = (sc < b) ? clamp(sc) : MAXS;
                v.move = mv;
            end
            else if (v.lower == v.upper)
            begin
                equal = 1'b1;
            end
            return v;
        endfunction

        function slot_rec_t fresh_slot(input update_t u, input int dt, input int a,
                                       input int b, input int sc, input int mv);
            slot_rec_t v;
            v.pkey = u.pkey;
            v.okey = u.okey;
            v.depth = u.depth;
            v.date = dt;
            v.lower = (sc > a) ? clamp(sc) : -MAXS;
            v.upper = (sc < b) ? clamp(sc) : MAXS;
            v.move = mv;
            return v;
        endfunction

        // Notes an accepted request and predicts its result.
        function void note_update(input update_t u);
            int idx, a, b, sc, mv, dt, depth;
            bit hit_d, hit_n, equal;
            slot_rec_t dv, nv, w;
            outcome_t r;
            if (u.req == REQ_CLEAR)
            begin
                wipe();
                r = '{act: ACT_CLEARED, lo: '0, up: '0, mv: '0, dt: '0};
                owed.push_back(r);
                return;
            end
            idx = int'(u.hash[32 +: TBITS]);
            a = $signed(u.wlo);
            b = $signed(u.whi);
            sc = $signed(u.score);
            mv = $signed(u.move);
            depth = u.depth;
            dt = date_reg;
            if (a < sc && sc < b) dt = bump(dt);
            dv = deep_slot[idx];
            nv = new_slot[idx];
            hit_d = (u.pkey == dv.pkey) && (u.okey == dv.okey);
            hit_n = (u.pkey == nv.pkey) && (u.okey == nv.okey);
            if (hit_d && depth == dv.depth)
            begin
                w = tighten(dv, a, b, sc, mv, equal);
                if (equal && dt == date_reg) dt = bump(dt);
                w.date = dt;
                deep_slot[idx] = w;
                r.act = ACT_REFINE_DEEP;
            end
            else if (hit_n && depth == nv.depth)
            begin
                w = tighten(nv, a, b, sc, mv, equal);
                w.date = dt;
                if (dt > dv.date || (dt == dv.date && depth > dv.depth))
                begin
                    new_slot[idx] = dv;
                    deep_slot[idx] = w;
                    r.act = ACT_PROMOTE;
                end
                else
                begin
                    new_slot[idx] = w;
                    r.act = ACT_REFINE_NEW;
                end
            end
            else if (hit_d || dv.date < dt || (dv.date == dt && dv.depth < depth))
            begin
                if (!hit_d && (hit_n || nv.date < dv.date ||
                               (nv.date == dv.date && nv.depth <= dv.depth)))
                    new_slot[idx] = dv;
                w = fresh_slot(u, dt, a, b, sc, mv);
                deep_slot[idx] = w;
                r.act = ACT_REPLACE_DEEP;
            end
            else
            begin
                w = fresh_slot(u, dt, a, b, sc, mv);
                new_slot[idx] = w;
                r.act = ACT_REPLACE_NEW;
            end
            r.lo = 8'(w.lower);
            r.up = 8'(w.upper);
            r.mv = 8'(w.move);
            r.dt = 8'(w.date);
            owed.push_back(r);
        endfunction

        // Compares an accepted result with the oldest prediction.
        task check_outcome(input outcome_t g);
            outcome_t e;
            if (owed.size() == 0)
            begin
                report_mismatch("unexpected result, action", g.act, -1);
                return;
            end
            e = owed.pop_front();
            if (g.act !== e.act) report_mismatch("action", g.act, e.act);
            if (g.lo !== e.lo) report_mismatch("stored_lower", $signed(g.lo), $signed(e.lo));
            if (g.up !== e.up) report_mismatch("stored_upper", $signed(g.up), $signed(e.up));
            if (g.mv !== e.mv) report_mismatch("stored_move", $signed(g.mv), $signed(e.mv));
            if (g.dt !== e.dt) report_mismatch("stored_date", g.dt, e.dt);
        endtask
    endclass

    cache_scoreboard sb = new();

    // Receiver stall pattern, redrawn at every rising edge.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // Transfers are observed mid-cycle, where all signals are settled.
    always @(negedge clk)
    begin
        outcome_t g;
        if (rst_n && out_valid && !out_stall)
        begin
            g = '{act: action, lo: stored_lower, up: stored_upper,
                  mv: stored_move, dt: stored_date};
            sb.check_outcome(g);
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // APB write of the search date; the caller is to issue it only while the block is idle, as the task does not check.
    task automatic write_date(input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'(4 * REG_SEARCH_DATE);
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.date_reg = value & 8'hFF;
    endtask

    // Waits until every predicted result has arrived, then lets the block settle.
    task automatic drain();
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Drives one request, with random idle cycles ahead of it.
    task automatic send_update(input update_t u);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= u.req;
        pos_hash <= u.hash;
        player_discs <= u.pkey;
        opponent_discs <= u.okey;
        search_depth <= u.depth;
        window_low <= u.wlo;
        window_high <= u.whi;
        result_score <= u.score;
        best_move <= u.move;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        sb.note_update(u);
    endtask

    function automatic update_t mk(input logic rq, input logic [63:0] h,
                                   input logic [63:0] p, input logic [63:0] o,
                                   input int d, input int a, input int b,
                                   input int sc, input int mv);
        update_t u;
        u = '{req: rq, hash: h, pkey: p, okey: o, depth: 8'(d), wlo: 8'(a),
              whi: 8'(b), score: 8'(sc), move: 8'(mv)};
        return u;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int near(input int center);
        return center + $urandom_range(0, 6) - 3;
    endfunction

    // Random request drawn mostly from a few buckets and keys, so slots collide.
    function automatic update_t random_update();
        update_t u;
        int k, sc;
        int depths [5] = '{0, 1, 2, 3, 255};
        u.req = ($urandom_range(199) == 0) ? REQ_CLEAR : REQ_STORE;
        u.hash = rand64();
        if ($urandom_range(9) != 0)
            u.hash[32 +: TBITS] = TBITS'($urandom_range(0, 5) * 1365);
        k = $urandom_range(0, 7);
        u.pkey = key_pool_p[k];
        u.okey = key_pool_o[k];
        if ($urandom_range(19) == 0)
        begin
            u.pkey = rand64();
            u.okey = rand64();
        end
        u.depth = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'(depths[$urandom_range(0, 4)]);
        sc = ($urandom_range(3) == 0) ? int'($signed(8'($urandom()))) : $urandom_range(0, 150) - 75;
        u.score = 8'(sc);
        if ($urandom_range(4) == 0)
        begin
            u.wlo = 8'($urandom());
            u.whi = 8'($urandom());
        end
        else
        begin
            u.wlo = 8'(near(sc) - 1);
            u.whi = 8'(near(sc) + 1);
        end
        u.move = 8'($urandom());
        return u;
    endfunction

    initial
    begin
        update_t dir [$];
        logic [63:0] kp, ko;
        int dates [6];
        kp = 64'h0000_0008_1000_0000;
        ko = 64'h0000_0010_0800_0000;
        key_pool_p[0] = '0;
        key_pool_o[0] = '0;
        key_pool_p[1] = '1;
        key_pool_o[1] = '1;
        key_pool_p[2] = kp;
        key_pool_o[2] = ko;
        for (int i = 3; i < 8; i++)
        begin
            key_pool_p[i] = rand64();
            key_pool_o[i] = rand64();
        end
        dates = '{0, 253, $urandom_range(1, 252), 1, 252, $urandom_range(0, 253)};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty slot refine, exact scores, saturation, repair,
        // promotion, replacement and a clear.
        send_idle = 0;
        recv_idle = 0;
        write_date(0);
        dir.push_back(mk(REQ_STORE, 64'h0, '0, '0, 0, -128, 127, 0, 5));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_FFFF_FFFF, kp, ko, 3, -10, 10, 2, 17));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_0000_0000, kp, ko, 3, -128, 127, 127, -1));
        dir.push_back(mk(REQ_STORE, 64'hFFFF_F005_1234_5678, kp, ko, 3, 127, -128, -128, 127));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_0000_0000, kp, ko, 3, 5, 7, 6, -128));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_0000_0000, kp, ko, 3, 30, 40, 35, 9));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_0000_0000, ~kp, ko, 1, -1, 1, 0, 3));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_0000_0000, ~kp, ko, 1, -5, 5, 4, 4));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_0000_0000, '1, '1, 255, 0, 0, 0, 1));
        dir.push_back(mk(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, 255, -128, 127, -100, 2));
        dir.push_back(mk(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, 255, -128, 127, 100, 3));
        dir.push_back(mk(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, 255, 100, -100, 0, 4));
        dir.push_back(mk(REQ_CLEAR, '1, '1, '1, 255, -1, -1, -1, -1));
        dir.push_back(mk(REQ_STORE, 64'h0000_0005_0000_0000, kp, ko, 3, -10, 10, 2, 17));
        foreach (dir[i]) send_update(dir[i]);
        in_valid <= 1'b0;
        drain();
        write_date(253);
        dir.delete();
        dir.push_back(mk(REQ_STORE, 64'h0000_0007_0000_0000, kp, ko, 2, -3, 3, 1, 1));
        dir.push_back(mk(REQ_STORE, 64'h0000_0007_0000_0000, kp, ko, 2, -3, 3, 1, 1));
        dir.push_back(mk(REQ_STORE, 64'h0000_0007_0000_0000, kp, ko, 2, 10, 20, 10, 6));
        dir.push_back(mk(REQ_STORE, 64'h0000_0007_0000_0000, kp, ~ko, 4, 10, 20, 10, 6));
        foreach (dir[i]) send_update(dir[i]);
        in_valid <= 1'b0;
        drain();

        // Random part in six phases, each with its own date; the idle profile changes every two phases.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_date(dates[ph]);
            send_idle = (ph < 2) ? 22 : (ph < 4) ? 51 : 0;
            recv_idle = (ph < 2) ? 51 : (ph < 4) ? 22 : 0;
            for (int n = 0; n < 90; n++)
            begin
                send_update(random_update());
                if ($urandom_range(29) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        recv_idle = 0;
        repeat (20) @(posedge clk);
        if (mismatches == 0 && sb.owed.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
src/tssc_pkg.sv
src/tssc_datapath.sv
src/tssc_ctrl.sv
src/two_slot_search_cache_update.sv
bench/two_slot_search_cache_update_tb.sv
